// ----- rtl/sm4_pkg.sv -----
// Package for the SM4 block cipher unit: S-box, FK/CK constants, round functions.
`default_nettype none
package sm4_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int KEY_WORDS  = 4;
    localparam int CFG_IDX_W  = 2;

    typedef logic [31:0] t_word;
    typedef logic [CFG_IDX_W:0] t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx IDX_KEY0 = t_cfg_idx'(0);
    localparam t_cfg_idx IDX_KEY1 = t_cfg_idx'(1);
    localparam t_cfg_idx IDX_KEY2 = t_cfg_idx'(2);
    localparam t_cfg_idx IDX_KEY3 = t_cfg_idx'(3);

    typedef struct packed {
        logic  valid;
        logic  func;
        t_word x0;
        t_word x1;
        t_word x2;
        t_word x3;
    } t_beat;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic t_word sub_word(input t_word x);
        sub_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic t_word rotl(input t_word x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // key schedule transform T'
    function automatic t_word key_t(input t_word x);
        t_word b;
        b = sub_word(x);
        key_t = b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // round transform T
    function automatic t_word rnd_t(input t_word x);
        t_word b;
        b = sub_word(x);
        rnd_t = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    // CK byte j of word i is ((4i+j)*7) mod 256
    function automatic t_word ck_word(input int i);
        t_word w;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            w = {w[23:0], 8'(((4 * i) + j) * 7)};
        end
        ck_word = w;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sm4_key_cell.sv -----
// One key schedule cell: derives one round key from the previous four words, registered.
`default_nettype none
module sm4_key_cell #(
    parameter int ROUND = 0
) (
    input  wire                 i_clk,
    input  wire sm4_pkg::t_word i_k0,
    input  wire sm4_pkg::t_word i_k1,
    input  wire sm4_pkg::t_word i_k2,
    input  wire sm4_pkg::t_word i_k3,
    output sm4_pkg::t_word      o_rk
);
    localparam sm4_pkg::t_word CK = sm4_pkg::ck_word(ROUND);

    sm4_pkg::t_word n_rk;
    sm4_pkg::t_word r_rk;

    assign n_rk = i_k0 ^ sm4_pkg::key_t(i_k1 ^ i_k2 ^ i_k3 ^ CK);

    always_ff @(posedge i_clk) begin
        r_rk <= n_rk;
    end

    assign o_rk = r_rk;
endmodule
`default_nettype wire

// ----- rtl/sm4_round_cell.sv -----
// One round cell of the cipher chain: one round, registered toward the next cell.
`default_nettype none
module sm4_round_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire sm4_pkg::t_beat i_beat,
    input  wire sm4_pkg::t_word i_rk_enc,
    input  wire sm4_pkg::t_word i_rk_dec,
    output sm4_pkg::t_beat      o_beat
);
    sm4_pkg::t_word w_rk;
    sm4_pkg::t_beat n_beat;
    sm4_pkg::t_beat r_beat;

    always_comb begin
        w_rk         = i_beat.func ? i_rk_dec : i_rk_enc;
        n_beat       = i_beat;
        n_beat.x0    = i_beat.x1;
        n_beat.x1    = i_beat.x2;
        n_beat.x2    = i_beat.x3;
        n_beat.x3    = i_beat.x0 ^ sm4_pkg::rnd_t(i_beat.x1 ^ i_beat.x2 ^ i_beat.x3 ^ w_rk);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
        r_beat.func <= n_beat.func;
        r_beat.x0   <= n_beat.x0;
        r_beat.x1   <= n_beat.x1;
        r_beat.x2   <= n_beat.x2;
        r_beat.x3   <= n_beat.x3;
    end

    assign o_beat = r_beat;
endmodule
`default_nettype wire

// ----- rtl/sm4_block_cipher_unit.sv -----
// SM4 cipher unit top level: key registers, key schedule chain, chain of 32 round cells.
// Each block is registered once in every round cell (one cell per round) on its way to the result strobe.
// Throughput: one block per cycle; start is taken every cycle while busy is low.
// Busy is high after reset and after each config write while the key chain settles: one round key per cycle.
// Reset (synchronous, active low) clears the key words and all in-flight valid bits.
// The receiver cannot stall: o_done pulses for one cycle with the result.
`default_nettype none
module sm4_block_cipher_unit (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire                                i_func,
    input  wire [63:0]                         i_block_hi,
    input  wire [63:0]                         i_block_lo,
    output logic                               o_done,
    output logic [63:0]                        o_result_hi,
    output logic [63:0]                        o_result_lo,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [sm4_pkg::CFG_IDX_W:0]         i_cfg_index,
    input  wire [31:0]                         i_cfg_data
);
    localparam int NR = sm4_pkg::NUM_ROUNDS;
    localparam logic [5:0] SETTLE_CYCLES = 6'(NR);

    sm4_pkg::t_word r_key [sm4_pkg::KEY_WORDS];
    sm4_pkg::t_word w_k   [NR + 4];
    sm4_pkg::t_beat w_chain [NR + 1];
    logic [5:0]     r_settle;
    logic [5:0]     n_settle;

    assign busy        = (r_settle != 6'd0);
    assign o_cfg_ready = 1'b1;

    // round keys ripple down the key chain; hold off blocks until the last one is ready
    always_comb begin
        n_settle = r_settle;
        if (r_settle != 6'd0) begin
            n_settle = r_settle - 6'd1;
        end
        if (i_cfg_valid && o_cfg_ready) begin
            n_settle = SETTLE_CYCLES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sm4_pkg::KEY_WORDS; i++) r_key[i] <= '0;
            r_settle <= SETTLE_CYCLES;
        end else begin
            r_settle <= n_settle;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sm4_pkg::IDX_KEY0: r_key[0] <= i_cfg_data;
                    sm4_pkg::IDX_KEY1: r_key[1] <= i_cfg_data;
                    sm4_pkg::IDX_KEY2: r_key[2] <= i_cfg_data;
                    sm4_pkg::IDX_KEY3: r_key[3] <= i_cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    assign w_k[0] = r_key[0] ^ sm4_pkg::FK0;
    assign w_k[1] = r_key[1] ^ sm4_pkg::FK1;
    assign w_k[2] = r_key[2] ^ sm4_pkg::FK2;
    assign w_k[3] = r_key[3] ^ sm4_pkg::FK3;

    // round key i is w_k[i+4]; the user must keep it static while blocks are in flight (not enforced here)
    for (genvar g = 0; g < NR; g++) begin : g_key
        sm4_key_cell #(.ROUND(g)) u_key (
            .i_clk (i_clk),
            .i_k0  (w_k[g]),
            .i_k1  (w_k[g + 1]),
            .i_k2  (w_k[g + 2]),
            .i_k3  (w_k[g + 3]),
            .o_rk  (w_k[g + 4])
        );
    end

    assign w_chain[0] = '{valid: start & ~busy, func: i_func,
                          x0: i_block_hi[63:32], x1: i_block_hi[31:0],
                          x2: i_block_lo[63:32], x3: i_block_lo[31:0]};

    for (genvar g = 0; g < NR; g++) begin : g_round
        sm4_round_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_beat   (w_chain[g]),
            .i_rk_enc (w_k[g + 4]),
            .i_rk_dec (w_k[NR - 1 - g + 4]),
            .o_beat   (w_chain[g + 1])
        );
    end

    assign o_done      = w_chain[NR].valid;
    assign o_result_hi = {w_chain[NR].x3, w_chain[NR].x2};
    assign o_result_lo = {w_chain[NR].x1, w_chain[NR].x0};

    // a result appears in the cycle after the last cell saw a valid beat
    a_last_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[NR - 1].valid |=> o_done) else $error("lost result beat");
    a_first_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> w_chain[1].valid) else $error("start beat not captured");
    a_idle_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_chain[NR - 1].valid |=> !o_done) else $error("spurious result beat");
    a_key_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> busy) else $error("busy low during key settle");
endmodule
`default_nettype wire
